// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/roc_pkg.sv =====
// ----------------------------------------------------------------------------
// roc_pkg
// Shared types, constants and box helpers for the room restrain core.
// ----------------------------------------------------------------------------
package roc_pkg;

  localparam int CoordBits  = 32;
  localparam int MaxResults = 5;
  localparam int LvlW       = $clog2(MaxResults);
  localparam logic [LvlW-1:0] LastLevel = LvlW'(MaxResults - 1);
  localparam int InDataW    = 12 * CoordBits;
  localparam int OutDataW   = 8 * CoordBits;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [CoordBits:0]   gap_t;

  // Axis-aligned box
  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } box_t;

  // Outcome of one restrain level
  typedef enum logic [1:0] {
    STEP_STOP  = 2'd0,
    STEP_CUT   = 2'd1,
    STEP_SPLIT = 2'd2
  } step_kind_e;

  typedef struct packed {
    step_kind_e kind;
    box_t       res_room;
    box_t       res_inner;
    box_t       next_room;
    box_t       next_inner;
  } step_res_t;

  // One room with its contained shape
  typedef struct packed {
    box_t room;
    box_t inner;
  } room_res_t;

  function automatic coord_t cmax(coord_t a, coord_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic coord_t cmin(coord_t a, coord_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic box_t isect(box_t a, box_t b);
    box_t r;
    r.x0 = cmax(a.x0, b.x0);
    r.y0 = cmax(a.y0, b.y0);
    r.x1 = cmin(a.x1, b.x1);
    r.y1 = cmin(a.y1, b.y1);
    return r;
  endfunction

  function automatic logic box_valid(box_t b);
    return (b.x0 <= b.x1) && (b.y0 <= b.y1);
  endfunction

  function automatic box_t mk_box(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
    box_t r;
    r.x0 = x0;
    r.y0 = y0;
    r.x1 = x1;
    r.y1 = y1;
    return r;
  endfunction

endpackage

// ===== rtl/roc_step_unit.sv =====
// ----------------------------------------------------------------------------
// roc_step_unit
// Shared evaluation unit for one restrain level: edge cut selection, overlap
// split and clipping of the contained shape.
// ----------------------------------------------------------------------------
module roc_step_unit import roc_pkg::*; (
  input  box_t      room_i,
  input  box_t      inner_i,
  input  box_t      obst_i,
  output step_res_t step_o
);

  logic cross_x, cross_y;
  logic q0, q1, q2, q3;
  gap_t g0, g1, g2, g3;
  logic v0, v1, v2, v3;
  logic sel01, sel23, sel_hi;
  logic v01, v23;
  gap_t g01, g23;
  logic [1:0] win;
  box_t cut_box;
  box_t ov, first_box, second_box, nc;
  logic split;
  logic nc_ok;

  // Gaps between contained shape and each obstacle edge
  assign cross_y = (room_i.y1 > obst_i.y0) && (room_i.y0 < obst_i.y1);
  assign cross_x = (room_i.x1 > obst_i.x0) && (room_i.x0 < obst_i.x1);

  assign q0 = (room_i.x0 < obst_i.x1) && (room_i.x1 > obst_i.x1) && cross_y;
  assign q1 = (room_i.x0 < obst_i.x0) && (room_i.x1 > obst_i.x0) && cross_y;
  assign q2 = (room_i.y0 < obst_i.y0) && (room_i.y1 > obst_i.y0) && cross_x;
  assign q3 = (room_i.y0 < obst_i.y1) && (room_i.y1 > obst_i.y1) && cross_x;

  assign g0 = gap_t'(inner_i.x0) - gap_t'(obst_i.x1);
  assign g1 = gap_t'(obst_i.x0) - gap_t'(inner_i.x1);
  assign g2 = gap_t'(obst_i.y0) - gap_t'(inner_i.y1);
  assign g3 = gap_t'(inner_i.y0) - gap_t'(obst_i.y1);

  assign v0 = q0 && (g0 > 0);
  assign v1 = q1 && (g1 > 0);
  assign v2 = q2 && (g2 > 0);
  assign v3 = q3 && (g3 > 0);

  // Largest gap wins, earlier edge on a tie
  assign sel01  = v1 && (!v0 || (g1 > g0));
  assign sel23  = v3 && (!v2 || (g3 > g2));
  assign v01    = v0 || v1;
  assign v23    = v2 || v3;
  assign g01    = sel01 ? g1 : g0;
  assign g23    = sel23 ? g3 : g2;
  assign sel_hi = v23 && (!v01 || (g23 > g01));
  assign win    = sel_hi ? {1'b1, sel23} : {1'b0, sel01};

  always_comb begin
    case (win)
      2'd0:    cut_box = mk_box(obst_i.x1, room_i.y0, room_i.x1, room_i.y1);
      2'd1:    cut_box = mk_box(room_i.x0, room_i.y0, obst_i.x0, room_i.y1);
      2'd2:    cut_box = mk_box(room_i.x0, room_i.y0, room_i.x1, obst_i.y0);
      default: cut_box = mk_box(room_i.x0, obst_i.y1, room_i.x1, room_i.y1);
    endcase
  end

  // Split at the obstacle edge bounding the overlap
  assign ov = isect(inner_i, obst_i);

  always_comb begin
    split      = 1'b1;
    first_box  = room_i;
    second_box = room_i;
    if ((ov.x0 > room_i.x0) && (ov.x0 == obst_i.x0) && (ov.x0 < room_i.x1)) begin
      first_box  = mk_box(room_i.x0, room_i.y0, ov.x0, room_i.y1);
      second_box = mk_box(ov.x0, room_i.y0, room_i.x1, room_i.y1);
    end else if ((ov.x1 > room_i.x0) && (ov.x1 == obst_i.x1) && (ov.x1 < room_i.x1)) begin
      second_box = mk_box(room_i.x0, room_i.y0, ov.x1, room_i.y1);
      first_box  = mk_box(ov.x1, room_i.y0, room_i.x1, room_i.y1);
    end else if ((ov.y0 > room_i.y0) && (ov.y0 == obst_i.y0) && (ov.y0 < room_i.y1)) begin
      first_box  = mk_box(room_i.x0, room_i.y0, room_i.x1, ov.y0);
      second_box = mk_box(room_i.x0, ov.y0, room_i.x1, room_i.y1);
    end else if ((ov.y1 > room_i.y0) && (ov.y1 == obst_i.y1) && (ov.y1 < room_i.y1)) begin
      second_box = mk_box(room_i.x0, room_i.y0, room_i.x1, ov.y1);
      first_box  = mk_box(room_i.x0, ov.y1, room_i.x1, room_i.y1);
    end else begin
      split = 1'b0;
    end
  end

  // Emitted piece needs a clipped shape with nonzero extent on at least one axis
  assign nc    = isect(inner_i, first_box);
  assign nc_ok = box_valid(nc) && ((nc.x0 < nc.x1) || (nc.y0 < nc.y1));

  // Level outcome
  always_comb begin
    step_o.res_room   = first_box;
    step_o.res_inner  = nc;
    step_o.next_room  = second_box;
    step_o.next_inner = isect(inner_i, second_box);
    if (!box_valid(inner_i)) begin
      step_o.kind = STEP_STOP;
    end else if (v01 || v23) begin
      step_o.kind      = STEP_CUT;
      step_o.res_room  = cut_box;
      step_o.res_inner = inner_i;
    end else if (box_valid(ov) && split && nc_ok) begin
      step_o.kind = STEP_SPLIT;
    end else begin
      step_o.kind = STEP_STOP;
    end
  end

endmodule

// ===== rtl/room_obstacle_restrain_core.sv =====
// ----------------------------------------------------------------------------
// room_obstacle_restrain_core
// Restrains a room box against one obstacle, giving up to five rooms.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one item: room, contained shape and obstacle boxes.
//   Master stream returns one to five rooms per item, each with its clipped
//   contained shape; tlast marks the final room, tuser flags an empty answer.
//   s_axis_tready_o is high only while the core is idle. After a transfer the
//   shared step unit evaluates one restrain level per cycle while the output
//   register can take the held room (at most five levels), then the flush state
//   releases the held final room once the output register is free.
//   One room is held back until the next level decides whether it is last.
//   When the receiver stalls, the sequencer waits on the output register and
//   the master payload holds steady. The input side reopens as soon as the
//   final room sits in the output register, while it may still be waiting.
//   Reset (rst_ni low, asynchronous) returns to idle and drops any pending
//   output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module room_obstacle_restrain_core import roc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // room_min_x, room_min_y, room_max_x, room_max_y, inner_min_x, inner_min_y,
  // inner_max_x, inner_max_y, obst_min_x, obst_min_y, obst_max_x, obst_max_y
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // out_room_min_x, out_room_min_y, out_room_max_x, out_room_max_y,
  // out_inner_min_x, out_inner_min_y, out_inner_max_x, out_inner_max_y
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tlast_o,  // is_last
  output logic                m_axis_tuser_o   // is_empty
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_STEP  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  typedef struct packed {
    room_res_t res;
    logic      last;
    logic      empty;
  } out_t;

  state_e          state_q, state_d;
  logic [LvlW-1:0] lvl_q, lvl_d;
  logic            pend_valid_q, pend_valid_d;
  logic            out_valid_q, out_valid_d;
  box_t            room_q, room_d;
  box_t            inner_q, inner_d;
  box_t            obst_q, obst_d;
  room_res_t       pend_q, pend_d;
  out_t            out_q, out_d;
  logic            out_load;
  logic            out_free;
  step_res_t       step;

  // Unpack one box of an input item
  function automatic box_t in_box(logic [InDataW-1:0] d, int base);
    box_t b;
    b.x0 = d[(base+0)*CoordBits +: CoordBits];
    b.y0 = d[(base+1)*CoordBits +: CoordBits];
    b.x1 = d[(base+2)*CoordBits +: CoordBits];
    b.y1 = d[(base+3)*CoordBits +: CoordBits];
    return b;
  endfunction

  // Shared level evaluation
  roc_step_unit u_step (
    .room_i  (room_q),
    .inner_i (inner_q),
    .obst_i  (obst_q),
    .step_o  (step)
  );

  assign out_free = !out_valid_q || m_axis_tready_i;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    lvl_d        = lvl_q;
    pend_valid_d = pend_valid_q;
    room_d       = room_q;
    inner_d      = inner_q;
    obst_d       = obst_q;
    pend_d       = pend_q;
    out_d        = out_q;
    out_load     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          room_d       = in_box(s_axis_tdata_i, 0);
          inner_d      = in_box(s_axis_tdata_i, 4);
          obst_d       = in_box(s_axis_tdata_i, 8);
          lvl_d        = '0;
          pend_valid_d = 1'b0;
          state_d      = ST_STEP;
        end
      end
      ST_STEP: begin
        if (step.kind == STEP_STOP) begin
          state_d = ST_FLUSH;
        end else if (!pend_valid_q || out_free) begin
          // held room is known not to be last now
          if (pend_valid_q) begin
            out_load    = 1'b1;
            out_d.res   = pend_q;
            out_d.last  = 1'b0;
            out_d.empty = 1'b0;
          end
          pend_d.room  = step.res_room;
          pend_d.inner = step.res_inner;
          pend_valid_d = 1'b1;
          if ((step.kind == STEP_CUT) || (lvl_q == LastLevel)) begin
            state_d = ST_FLUSH;
          end else begin
            lvl_d   = lvl_q + LvlW'(1);
            room_d  = step.next_room;
            inner_d = step.next_inner;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_d.last = 1'b1;
          if (pend_valid_q) begin
            out_d.res   = pend_q;
            out_d.empty = 1'b0;
          end else begin
            out_d.res   = '0;
            out_d.empty = 1'b1;
          end
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready_i);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      lvl_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      lvl_q        <= lvl_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    room_q  <= room_d;
    inner_q <= inner_d;
    obst_q  <= obst_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  // Ports
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tuser_o  = out_q.empty;
  assign m_axis_tdata_o  = {out_q.res.inner.y1, out_q.res.inner.x1,
                            out_q.res.inner.y0, out_q.res.inner.x0,
                            out_q.res.room.y1,  out_q.res.room.x1,
                            out_q.res.room.y0,  out_q.res.room.x0};

  // Checks
  `ASSERT_CLK(a_empty_is_last, m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o, "empty result without tlast")
  `ASSERT_NEVER(a_idle_no_pend, s_axis_tready_o && pend_valid_q, "held room left over while idle")
  `ASSERT_CLK(a_flush_loads, (state_q == ST_FLUSH) && out_free |=> m_axis_tvalid_o && m_axis_tlast_o, "flush did not present final room")
  `ASSERT_NEVER(a_lvl_range, lvl_q > LastLevel, "level counter out of range")

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// room_obstacle_restrain_core testbench
// Feeds room / contained shape / obstacle triples over the slave stream and
// checks master rooms against an in-bench restrain model or a table answer.
// A short directed table comes first, then shaped and raw random items, with
// random idling on both sides, one long receiver hold-off and input drains.
// ----------------------------------------------------------------------------
module testbench;
  import roc_pkg::*;

  localparam coord_t CMIN = {1'b1, {(CoordBits - 1){1'b0}}};
  localparam coord_t CMAX = {1'b0, {(CoordBits - 1){1'b1}}};
  localparam int DIR_ROWS   = 18;
  localparam int RAND_ITEMS = 480;
  localparam int HOLD_CYCLES = 300;

  // One input item; fields in stream order, first field in the top bits here
  typedef struct packed {
    box_t room;
    box_t inner;
    box_t obst;
  } item_t;

  // One room as it should leave the core
  typedef struct packed {
    box_t room;
    box_t inner;
    logic last;
    logic empty;
  } result_t;

  typedef struct packed {
    box_t    room;
    box_t    inner;
    box_t    obst;
    logic    typed;  // want holds the full answer (a single room)
    result_t want;
  } dir_row_t;

  // Wide working copy of a box, so gaps never overflow
  typedef struct {
    longint x0, y0, x1, y1;
  } rect_t;

  localparam result_t NO_RES    = '0;
  localparam result_t EMPTY_RES = '{'{0, 0, 0, 0}, '{0, 0, 0, 0}, 1'b1, 1'b1};

  // Directed table: boxes are '{min_x, min_y, max_x, max_y}
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // left obstacle edge cuts the room
    '{'{0, 0, 100, 100}, '{10, 10, 20, 20}, '{50, 0, 60, 100}, 1'b1,
      '{'{0, 0, 50, 100}, '{10, 10, 20, 20}, 1'b1, 1'b0}},
    // contained shape inverted in x, then in y
    '{'{0, 0, 10, 10}, '{5, 0, 4, 10}, '{2, 2, 3, 3}, 1'b1, EMPTY_RES},
    '{'{0, 0, 10, 10}, '{0, 6, 10, 5}, '{2, 2, 3, 3}, 1'b1, EMPTY_RES},
    // every field at the lowest, then the highest value
    '{'{CMIN, CMIN, CMIN, CMIN}, '{CMIN, CMIN, CMIN, CMIN}, '{CMIN, CMIN, CMIN, CMIN},
      1'b1, EMPTY_RES},
    '{'{CMAX, CMAX, CMAX, CMAX}, '{CMAX, CMAX, CMAX, CMAX}, '{CMAX, CMAX, CMAX, CMAX},
      1'b1, EMPTY_RES},
    // right edge cut with a gap wider than the coordinate range
    '{'{CMIN, CMIN, CMAX, CMAX}, '{CMAX - 1, 0, CMAX, 10}, '{CMIN, CMIN, CMIN + 1, CMAX},
      1'b1, '{'{CMIN + 1, CMIN, CMAX, CMAX}, '{CMAX - 1, 0, CMAX, 10}, 1'b1, 1'b0}},
    // obstacle inside the shape: split at each obstacle edge in turn
    '{'{0, 0, 100, 100}, '{10, 10, 90, 90}, '{40, 40, 60, 60}, 1'b0, NO_RES},
    // right, lower and upper edge cuts
    '{'{0, 0, 100, 100}, '{70, 10, 90, 20}, '{20, 0, 40, 100}, 1'b0, NO_RES},
    '{'{0, 0, 100, 100}, '{10, 10, 20, 20}, '{0, 50, 100, 60}, 1'b0, NO_RES},
    '{'{0, 0, 100, 100}, '{10, 70, 20, 90}, '{0, 20, 100, 40}, 1'b0, NO_RES},
    // equal gaps on right and upper edge: the right edge wins
    '{'{0, 0, 100, 100}, '{50, 50, 60, 60}, '{20, 20, 30, 30}, 1'b0, NO_RES},
    // obstacle outside the room
    '{'{0, 0, 10, 10}, '{2, 2, 8, 8}, '{20, 20, 30, 30}, 1'b0, NO_RES},
    // first split piece only a line: still emitted
    '{'{0, 0, 100, 100}, '{40, 10, 90, 90}, '{40, 40, 60, 60}, 1'b0, NO_RES},
    // inverted room, inverted obstacle
    '{'{100, 100, 0, 0}, '{10, 10, 20, 20}, '{40, 40, 60, 60}, 1'b0, NO_RES},
    '{'{0, 0, 100, 100}, '{10, 10, 90, 90}, '{60, 60, 40, 40}, 1'b0, NO_RES},
    // point shape inside a small obstacle in a full-range room
    '{'{CMIN, CMIN, CMAX, CMAX}, '{0, 0, 0, 0}, '{-1, -1, 1, 1}, 1'b0, NO_RES},
    // alternating bit patterns
    '{'{32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555, 32'h55555555}, '{0, 0, 16, 16},
      '{-8, -8, 8, 8}, 1'b0, NO_RES},
    // obstacle equal to the shape
    '{'{0, 0, 100, 100}, '{20, 20, 80, 80}, '{20, 20, 80, 80}, 1'b0, NO_RES}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic                m_axis_tuser_o;

  result_t rooms_due [$];
  int      mismatches = 0;
  bit      calm       = 1'b0;  // no idling on either side
  bit      hold_req   = 1'b0;  // ask the receiver for a long hold-off

  string box_field [8] = '{"out_room_min_x", "out_room_min_y", "out_room_max_x",
                           "out_room_max_y", "out_inner_min_x", "out_inner_min_y",
                           "out_inner_max_x", "out_inner_max_y"};

  room_obstacle_restrain_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Append one room to the expected list
  function automatic void expect_room(result_t r);
    rooms_due.insert(rooms_due.size(), r);
  endfunction

  // --------------------------------------------------------------------------
  // Restrain model
  // --------------------------------------------------------------------------
  function automatic rect_t rect_of(longint x0, longint y0, longint x1, longint y1);
    rect_t r;
    r.x0 = x0;
    r.y0 = y0;
    r.x1 = x1;
    r.y1 = y1;
    return r;
  endfunction

  function automatic rect_t widen(box_t b);
    return rect_of(longint'(b.x0), longint'(b.y0), longint'(b.x1), longint'(b.y1));
  endfunction

  function automatic box_t narrow(rect_t r);
    box_t b;
    b.x0 = coord_t'(r.x0);
    b.y0 = coord_t'(r.y0);
    b.x1 = coord_t'(r.x1);
    b.y1 = coord_t'(r.y1);
    return b;
  endfunction

  // -1 when inverted, else number of axes with nonzero extent
  function automatic int rect_dim(rect_t b);
    if (b.x0 > b.x1 || b.y0 > b.y1) return -1;
    return int'(b.x0 < b.x1) + int'(b.y0 < b.y1);
  endfunction

  function automatic rect_t overlap_of(rect_t a, rect_t b);
    return rect_of((a.x0 > b.x0) ? a.x0 : b.x0, (a.y0 > b.y0) ? a.y0 : b.y0,
                   (a.x1 < b.x1) ? a.x1 : b.x1, (a.y1 < b.y1) ? a.y1 : b.y1);
  endfunction

  // Work out all rooms of one item and queue them
  task automatic predict_rooms(input item_t it);
    rect_t   room, cont, ob, cut, ov, first, second, nc;
    longint  best;
    bit      have, split, cross_x, cross_y;
    int      n;
    result_t found [MaxResults];
    room = widen(it.room);
    cont = widen(it.inner);
    ob   = widen(it.obst);
    n    = 0;
    for (int lvl = 0; lvl < MaxResults && n < MaxResults; lvl++) begin
      if (rect_dim(cont) < 0) break;
      best    = 0;
      have    = 1'b0;
      cut     = room;
      cross_y = room.y1 > ob.y0 && room.y0 < ob.y1;
      cross_x = room.x1 > ob.x0 && room.x0 < ob.x1;
      // single cut: farthest edge with a positive gap, earlier edge on a tie
      if (room.x0 < ob.x1 && room.x1 > ob.x1 && cross_y && cont.x0 - ob.x1 > best) begin
        best = cont.x0 - ob.x1;
        cut  = rect_of(ob.x1, room.y0, room.x1, room.y1);
        have = 1'b1;
      end
      if (room.x0 < ob.x0 && room.x1 > ob.x0 && cross_y && ob.x0 - cont.x1 > best) begin
        best = ob.x0 - cont.x1;
        cut  = rect_of(room.x0, room.y0, ob.x0, room.y1);
        have = 1'b1;
      end
      if (room.y0 < ob.y0 && room.y1 > ob.y0 && cross_x && ob.y0 - cont.y1 > best) begin
        best = ob.y0 - cont.y1;
        cut  = rect_of(room.x0, room.y0, room.x1, ob.y0);
        have = 1'b1;
      end
      if (room.y0 < ob.y1 && room.y1 > ob.y1 && cross_x && cont.y0 - ob.y1 > best) begin
        cut  = rect_of(room.x0, ob.y1, room.x1, room.y1);
        have = 1'b1;
      end
      if (have) begin
        found[n] = '{narrow(cut), narrow(cont), 1'b0, 1'b0};
        n++;
        break;
      end
      // split at an obstacle edge bounding the overlap
      ov = overlap_of(cont, ob);
      if (rect_dim(ov) < 0) break;
      split = 1'b1;
      if (ov.x0 > room.x0 && ov.x0 == ob.x0 && ov.x0 < room.x1) begin
        first  = rect_of(room.x0, room.y0, ov.x0, room.y1);
        second = rect_of(ov.x0, room.y0, room.x1, room.y1);
      end else if (ov.x1 > room.x0 && ov.x1 == ob.x1 && ov.x1 < room.x1) begin
        second = rect_of(room.x0, room.y0, ov.x1, room.y1);
        first  = rect_of(ov.x1, room.y0, room.x1, room.y1);
      end else if (ov.y0 > room.y0 && ov.y0 == ob.y0 && ov.y0 < room.y1) begin
        first  = rect_of(room.x0, room.y0, room.x1, ov.y0);
        second = rect_of(room.x0, ov.y0, room.x1, room.y1);
      end else if (ov.y1 > room.y0 && ov.y1 == ob.y1 && ov.y1 < room.y1) begin
        second = rect_of(room.x0, room.y0, room.x1, ov.y1);
        first  = rect_of(room.x0, ov.y1, room.x1, room.y1);
      end else begin
        split = 1'b0;
      end
      if (!split) break;
      nc = overlap_of(cont, first);
      if (rect_dim(nc) <= 0) break;
      found[n] = '{narrow(first), narrow(nc), 1'b0, 1'b0};
      n++;
      cont = overlap_of(cont, second);
      room = second;
    end
    if (n == 0) begin
      found[0] = EMPTY_RES;
      n = 1;
    end
    found[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) expect_room(found[i]);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [InDataW-1:0] pack_item(item_t it);
    logic [InDataW-1:0] d;
    for (int i = 0; i < 12; i++)
      d[i * CoordBits +: CoordBits] = it[InDataW - 1 - i * CoordBits -: CoordBits];
    return d;
  endfunction

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 7))
      0:       return CMIN;
      1:       return CMIN + 1;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return CMAX - 1;
      6:       return CMAX;
      default: return coord_t'($urandom());
    endcase
  endfunction

  // One axis of a mostly well-formed item: room around the shape, obstacle nearby
  function automatic void shape_axis(output coord_t r0, r1, i0, i1, o0, o1);
    longint base, a0, a1, t;
    case ($urandom_range(0, 7))
      0: base = longint'(CMIN) + 16;
      1: base = longint'(CMAX) - 120;
      2, 3: begin
        base = longint'($signed($urandom()));
        if (base < longint'(CMIN) + 16) base = longint'(CMIN) + 16;
        if (base > longint'(CMAX) - 120) base = longint'(CMAX) - 120;
      end
      default: base = -40;
    endcase
    a0 = base + longint'($urandom_range(0, 24));
    a1 = a0 + longint'($urandom_range(0, 24));
    if ($urandom_range(0, 19) == 0) begin
      t  = a0;
      a0 = a1 + 1;
      a1 = t;
    end
    i0 = coord_t'(a0);
    i1 = coord_t'(a1);
    if ($urandom_range(0, 9) == 0) begin
      r0 = coord_t'(base + longint'($urandom_range(0, 60)));
      r1 = coord_t'(base + longint'($urandom_range(0, 60)));
    end else begin
      r0 = coord_t'(a0 - longint'($urandom_range(0, 12)));
      r1 = coord_t'(a1 + longint'($urandom_range(0, 12)));
    end
    t  = base - 6 + longint'($urandom_range(0, 60));
    o0 = coord_t'(t);
    o1 = coord_t'(t + longint'($urandom_range(0, 30)));
    if ($urandom_range(0, 11) == 0) begin
      o0 = o1;
      o1 = coord_t'(t);
    end
  endfunction

  function automatic item_t random_item();
    item_t       it;
    coord_t      f [12];
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      for (int i = 0; i < 12; i++) f[i] = coord_t'($urandom());
    end else if (mode == 1) begin
      for (int i = 0; i < 12; i++) f[i] = pick_extreme();
    end else begin
      shape_axis(f[0], f[2], f[4], f[6], f[8], f[10]);
      shape_axis(f[1], f[3], f[5], f[7], f[9], f[11]);
    end
    for (int i = 0; i < 12; i++) it[InDataW - 1 - i * CoordBits -: CoordBits] = f[i];
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Sender, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    item_t it;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int k = 0; k < DIR_ROWS + RAND_ITEMS; k++) begin
      if (k < DIR_ROWS) it = {DIR_TAB[k].room, DIR_TAB[k].inner, DIR_TAB[k].obst};
      else it = random_item();
      calm = (k >= DIR_ROWS + 200) && (k < DIR_ROWS + 300);
      if (k == DIR_ROWS + 100) hold_req = 1'b1;
      if (k == DIR_ROWS || k == DIR_ROWS + 350) begin
        // drain: hold input until every queued room has come out
        s_axis_tvalid_i <= 1'b0;
        do @(posedge clk_i); while (rooms_due.size() != 0);
      end else if (!calm && $urandom_range(0, 99) < 8) begin
        s_axis_tvalid_i <= 1'b0;
        do @(posedge clk_i); while ($urandom_range(0, 99) < 8);
      end
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= pack_item(it);
      do @(posedge clk_i); while (!s_axis_tready_o);
      if (k < DIR_ROWS && DIR_TAB[k].typed) expect_room(DIR_TAB[k].want);
      else predict_rooms(it);
    end
    s_axis_tvalid_i <= 1'b0;
    while (rooms_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("room_obstacle_restrain_core verification clean");
    end else begin
      $display("room_obstacle_restrain_core verification failed");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= calm || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  // Check each master transfer against the oldest queued room
  always @(posedge clk_i) begin
    result_t             want;
    logic [OutDataW-1:0] wanted;
    coord_t              e, a;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (rooms_due.size() == 0) begin
        $error("room transfer with nothing expected");
        mismatches++;
      end else begin
        want   = rooms_due.pop_front();
        wanted = {want.room, want.inner};
        for (int i = 0; i < 8; i++) begin
          e = wanted[OutDataW - 1 - i * CoordBits -: CoordBits];
          a = m_axis_tdata_o[i * CoordBits +: CoordBits];
          if (e !== a) begin
            $error("%s: expected %0d, got %0d", box_field[i], e, a);
            mismatches++;
          end
        end
        if (want.last !== m_axis_tlast_o) begin
          $error("is_last: expected %0d, got %0d", want.last, m_axis_tlast_o);
          mismatches++;
        end
        if (want.empty !== m_axis_tuser_o) begin
          $error("is_empty: expected %0d, got %0d", want.empty, m_axis_tuser_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("room_obstacle_restrain_core verification failed");
    $finish;
  end

endmodule
